/* rtl/nafa_pkg.sv */
// ----------------------------------------------------------------------------
// nafa_pkg
// Shared types, constants and helpers of the neighbor-aware frame allocator.
// ----------------------------------------------------------------------------
package nafa_pkg;

	localparam int NUM_FRAMES_DEF     = 65536;
	localparam int UNTAGGED_BELOW_DEF = 1024;

	// free map row geometry
	localparam int ROW_BITS  = 16;
	localparam int ROW_IDX_W = 4;

	localparam logic [15:0] TAG_UNTOUCHED = 16'h0000;
	localparam logic [15:0] TAG_FREE      = 16'hFFFF;
	localparam logic [15:0] TAG_UNKNOWN   = 16'hFFFE;

	localparam logic [15:0] LOWEST_RST = 16'd0;
	localparam logic [16:0] LIMIT_RST  = 17'd57344;

	localparam logic REG_LOWEST = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	typedef enum logic [1:0] {
		OP_FREE    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_ALLOC_U = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NOFRAME = 2'd1,
		ST_BOUNDS  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] frame;
		logic [14:0] pid;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        frame_out;
		logic signed [15:0] tag_out;
	} rsp_t;

	typedef struct packed {
		logic [15:0] lowest_frame;
		logic [16:0] frame_limit;
	} cfg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FREE_RD,
		S_FREE_WR,
		S_READ_RD,
		S_READ_OUT,
		S_ROW_RD,
		S_ROW_WAIT,
		S_PICK,
		S_LEFT_RD,
		S_LEFT_CHK,
		S_RIGHT_CHK,
		S_FIN_RD,
		S_FIN
	} state_t;

	// index of highest set bit
	function automatic logic [ROW_IDX_W-1:0] hi_bit(input logic [ROW_BITS-1:0] v);
		logic [ROW_IDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < ROW_BITS; i++) begin
			if (v[i]) r = ROW_IDX_W'(i);
		end
		return r;
	endfunction

	function automatic logic pair_ok(input logic [15:0] l, input logic [15:0] r,
		input logic [15:0] p);
		return (l == TAG_FREE && r == TAG_FREE) || (l == p && r == TAG_FREE) ||
			(l == TAG_FREE && r == p) || (l == p && r == p) ||
			(l == p && r == TAG_UNKNOWN) || (l == TAG_UNKNOWN && r == p) ||
			(l == TAG_FREE && r == TAG_UNKNOWN) || (l == TAG_UNKNOWN && r == TAG_FREE);
	endfunction

endpackage

/* rtl/neighbor_aware_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// neighbor_aware_frame_allocator_top
// Page-frame allocator with per-frame free bit and owner tag in on-chip RAM.
// ----------------------------------------------------------------------------
// One request at a time: start is taken when busy is low, and the single
// result shows on rsp for exactly one cycle with done high; the receiver
// cannot stall it, so it must take it then. After reset the block sweeps
// both RAMs to zero, one frame per cycle, with busy high; the config port
// works throughout. Free reads the free-map row and writes it back; read
// reads the tag. Allocations walk the free map from the top, 16 frames per
// row read; a pid allocation also reads both neighbor tags of each
// candidate through the single tag RAM port before it finishes. A failed
// search walks every row of the free map, and a pid search also checks
// each free frame that it rejects.
// ----------------------------------------------------------------------------
module neighbor_aware_frame_allocator_top import nafa_pkg::*; #(
	parameter int NUM_FRAMES     = NUM_FRAMES_DEF,
	parameter int UNTAGGED_BELOW = UNTAGGED_BELOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int FW   = $clog2(NUM_FRAMES);
	localparam int ROWS = (NUM_FRAMES + ROW_BITS - 1) / ROW_BITS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	cfg_t cfg;

	nafa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// RAMs: owner tags per frame, free bits packed 16 per row
	logic [15:0]         tag_mem [NUM_FRAMES];
	logic [ROW_BITS-1:0] row_mem [ROWS];

	logic          tag_we;
	logic [FW-1:0] tag_waddr, tag_raddr;
	logic [15:0]   tag_wdata, tag_rd;
	logic          row_we;
	logic [RW-1:0] row_waddr, row_raddr;
	logic [ROW_BITS-1:0] row_wdata, row_rd;

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
		tag_rd <= tag_mem[tag_raddr];
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_waddr] <= row_wdata;
		row_rd <= row_mem[row_raddr];
	end

	state_t state_q, state_d;

	req_t                 req_q;
	logic [FW-1:0]        clr_q;
	logic [FW-1:0]        f_q;
	logic [RW-1:0]        rowcnt_q;
	logic [ROW_BITS-1:0]  rowbits_q;
	logic [ROW_BITS-1:0]  cand_q;
	logic [ROW_IDX_W-1:0] bit_q;
	logic [15:0]          left_q;
	rsp_t                 rsp_q;
	logic                 done_q;

	// request decode
	logic          oob_free, oob_read;
	logic [FW-1:0] frame_idx;

	assign frame_idx = FW'(32'(req.frame));
	assign oob_read  = 32'(req.frame) >= 32'(NUM_FRAMES);
	assign oob_free  = oob_read || (req.frame < cfg.lowest_frame) ||
		({1'b0, req.frame} >= cfg.frame_limit);

	// candidate pick
	logic [ROW_IDX_W-1:0] pick_bit;
	logic [RW+ROW_IDX_W-1:0] pick_wide;
	logic [FW-1:0]        pick_f;

	assign pick_bit  = hi_bit(cand_q);
	assign pick_wide = {rowcnt_q, pick_bit};
	assign pick_f    = FW'(pick_wide);

	// neighbor positions
	logic has_left, has_right;
	logic [15:0] left_tag, right_tag, own_tag, new_tag;
	logic set_tag;

	assign has_left  = (f_q != '0);
	assign has_right = (32'(f_q) + 32'd1) < 32'(NUM_FRAMES);
	assign left_tag  = (!has_left || tag_rd == TAG_UNTOUCHED) ? TAG_FREE : tag_rd;
	assign right_tag = (!has_right || tag_rd == TAG_UNTOUCHED) ? TAG_FREE : tag_rd;
	assign own_tag   = (req_q.op == OP_ALLOC) ? {1'b0, req_q.pid} : TAG_UNKNOWN;
	assign set_tag   = 32'(f_q) >= 32'(UNTAGGED_BELOW);
	assign new_tag   = set_tag ? own_tag : tag_rd;

	logic [RW-1:0] f_row;
	assign f_row = RW'(32'(f_q) >> ROW_IDX_W);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:   if (32'(clr_q) == 32'(NUM_FRAMES - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (start) begin
					unique case (op_t'(req.op))
						OP_FREE:    state_d = oob_free ? S_IDLE : S_FREE_RD;
						OP_READ:    state_d = oob_read ? S_IDLE : S_READ_RD;
						OP_ALLOC,
						OP_ALLOC_U: state_d = S_ROW_RD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_FREE_RD:   state_d = S_FREE_WR;
			S_FREE_WR:   state_d = S_IDLE;
			S_READ_RD:   state_d = S_READ_OUT;
			S_READ_OUT:  state_d = S_IDLE;
			S_ROW_RD:    state_d = S_ROW_WAIT;
			S_ROW_WAIT:  state_d = S_PICK;
			S_PICK: begin
				priority if (cand_q == '0)
					state_d = (rowcnt_q == '0) ? S_IDLE : S_ROW_RD;
				else if (req_q.op == OP_ALLOC_U)
					state_d = S_FIN_RD;
				else
					state_d = S_LEFT_RD;
			end
			S_LEFT_RD:   state_d = S_LEFT_CHK;
			S_LEFT_CHK:  state_d = S_RIGHT_CHK;
			S_RIGHT_CHK: state_d = pair_ok(left_q, right_tag, {1'b0, req_q.pid}) ?
				S_FIN_RD : S_PICK;
			S_FIN_RD:    state_d = S_FIN;
			S_FIN:       state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = f_q;
		tag_wdata = TAG_FREE;
		tag_raddr = f_q;
		row_we    = 1'b0;
		row_waddr = rowcnt_q;
		row_wdata = rowbits_q;
		row_raddr = rowcnt_q;
		unique case (state_q)
			S_CLEAR: begin
				tag_we    = 1'b1;
				tag_waddr = clr_q;
				tag_wdata = TAG_UNTOUCHED;
				row_we    = 32'(clr_q) < 32'(ROWS);
				row_waddr = RW'(32'(clr_q));
				row_wdata = '0;
			end
			S_FREE_RD:  row_raddr = f_row;
			S_FREE_WR: begin
				row_we    = 1'b1;
				row_waddr = f_row;
				row_wdata = row_rd | (ROW_BITS'(1) << f_q[ROW_IDX_W-1:0]);
				tag_we    = 1'b1;
			end
			S_LEFT_RD:  tag_raddr = f_q - FW'(1);
			S_LEFT_CHK: begin
				tag_we    = has_left && tag_rd == TAG_UNTOUCHED;
				tag_waddr = f_q - FW'(1);
				tag_raddr = f_q + FW'(1);
			end
			S_RIGHT_CHK: begin
				tag_we    = has_right && tag_rd == TAG_UNTOUCHED;
				tag_waddr = f_q + FW'(1);
			end
			S_FIN: begin
				tag_we    = set_tag;
				tag_wdata = own_tag;
				row_we    = 1'b1;
				row_wdata = rowbits_q & ~(ROW_BITS'(1) << bit_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == S_CLEAR) clr_q <= clr_q + FW'(1);
			unique case (state_q)
				S_IDLE:     done_q <= start && ((req.op == OP_FREE && oob_free) ||
					(req.op == OP_READ && oob_read));
				S_FREE_WR, S_READ_OUT, S_FIN: done_q <= 1'b1;
				S_PICK:     done_q <= (cand_q == '0) && (rowcnt_q == '0);
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q    <= req;
				f_q      <= frame_idx;
				rowcnt_q <= RW'(ROWS - 1);
				rsp_q.status    <= ST_BOUNDS;
				rsp_q.frame_out <= req.frame;
				rsp_q.tag_out   <= '0;
			end
			S_FREE_WR: begin
				rsp_q.status  <= ST_DONE;
				rsp_q.tag_out <= TAG_FREE;
			end
			S_READ_OUT: begin
				rsp_q.status  <= ST_DONE;
				rsp_q.tag_out <= tag_rd;
			end
			S_ROW_WAIT: begin
				rowbits_q <= row_rd;
				cand_q    <= row_rd;
			end
			S_PICK: begin
				if (cand_q == '0) begin
					rowcnt_q        <= rowcnt_q - RW'(1);
					rsp_q.status    <= ST_NOFRAME;
					rsp_q.frame_out <= '0;
					rsp_q.tag_out   <= '0;
				end else begin
					f_q   <= pick_f;
					bit_q <= pick_bit;
				end
			end
			S_LEFT_CHK:  left_q <= left_tag;
			S_RIGHT_CHK: cand_q <= cand_q & ~(ROW_BITS'(1) << bit_q);
			S_FIN: begin
				rsp_q.status    <= ST_DONE;
				rsp_q.frame_out <= 16'(32'(f_q));
				rsp_q.tag_out   <= new_tag;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* rtl/nafa_regs.sv */
// ----------------------------------------------------------------------------
// nafa_regs
// APB configuration registers: lowest frame and frame limit.
// ----------------------------------------------------------------------------
module nafa_regs import nafa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [15:0] lowest_q;
	logic [16:0] limit_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= LOWEST_RST;
			limit_q  <= LIMIT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_LOWEST: lowest_q <= pwdata[15:0];
				REG_LIMIT:  limit_q  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LOWEST: prdata = {16'd0, lowest_q};
			REG_LIMIT:  prdata = {15'd0, limit_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.lowest_frame = lowest_q;
	assign cfg.frame_limit  = limit_q;

endmodule
